// File: rtl/nalep_pkg.sv
// Shared types and constants for the NAL unit writer with emulation prevention.
// Holds command and result codes, the result burst record and stream constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package nalep_pkg;

	localparam int COUNT_BITS_DEF = 24;
	localparam int LEN_BITS       = 24;
	localparam int CAP_BITS       = 24;
	localparam int BURST_MAX      = 5;

	localparam logic [7:0] EPB = 8'h03;
	localparam logic [3:0][7:0] START_PREFIX = {8'h01, 8'h00, 8'h00, 8'h00};
	localparam logic FORBIDDEN_ZERO = 1'b0;

	typedef enum logic [1:0] {
		CMD_START   = 2'd0,
		CMD_PAYLOAD = 2'd1,
		CMD_END     = 2'd2,
		CMD_CLEAR   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_BYTE = 2'd0,
		KIND_FULL = 2'd1,
		KIND_DONE = 2'd2
	} kind_t;

	typedef enum logic {
		REG_CAPACITY = 1'b0,
		REG_PAD      = 1'b1
	} reg_idx_t;

	// results still to send: bytes[0] is the one on the output
	typedef struct packed {
		logic [2:0]                 count;
		logic [BURST_MAX-1:0][7:0]  bytes;
		kind_t                      tail_kind;
		logic [LEN_BITS-1:0]        tail_len;
	} burst_t;

endpackage

`default_nettype wire

// File: rtl/h264_nal_emulation_prevention_writer_top.sv
// Annex B NAL unit writer with emulation prevention, single module.
// Depends on nalep_pkg for codes, constants and the result burst record.
//
// Usage: commands enter on the input channel (in_valid/in_stall) with the
// fields command, nal_type, ref_priority, payload_len and data_byte. Results
// leave one per transfer on the output channel (out_valid/out_stall) as
// out_byte, kind, unit_length and last; last marks the final result of a
// command. Registers buffer_capacity (0x0) and trailing_zero_pad (0x4) sit
// on the APB port; write them only while the block is idle.
// The first result of a command appears once the command has passed the input
// register and the result register. Throughput: one command per cycle while
// each command gives at most one result and the receiver does not stall; a
// command giving several results (start 5, escaped payload 2, padded end 2)
// holds the next command in the input register until its final result leaves;
// the single result register sends one result a cycle while not stalled.
// Reset clears the unit state, the occupancy count and both pipeline
// stages; the registers return to capacity 0xFFFFFF and padding on.
// A stalled receiver holds the current result; the input register then
// fills and in_stall rises until the final result of the burst leaves.
`timescale 1ns / 1ps
`default_nettype none

module h264_nal_emulation_prevention_writer_top #(
	parameter int COUNT_BITS = nalep_pkg::COUNT_BITS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// input channel
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic [1:0]                     command,
	input  wire logic [4:0]                     nal_type,
	input  wire logic [1:0]                     ref_priority,
	input  wire logic [nalep_pkg::LEN_BITS-1:0] payload_len,
	input  wire logic [7:0]                     data_byte,
	// output channel
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic [7:0]                          out_byte,
	output logic [1:0]                          kind,
	output logic [nalep_pkg::LEN_BITS-1:0]      unit_length,
	output logic                                last,
	// configuration
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [2:0]                     paddr,
	input  wire logic [31:0]                    pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready
);
	import nalep_pkg::*;

	localparam int NEED_W = ((COUNT_BITS > CAP_BITS) ? COUNT_BITS : CAP_BITS) + 2;

	// configuration registers
	logic [CAP_BITS-1:0] capacity_q;
	logic                pad_q;

	// input stage
	logic                v_s1;
	cmd_t                cmd_s1;
	logic [4:0]          type_s1;
	logic [1:0]          ref_s1;
	logic [LEN_BITS-1:0] len_s1;
	logic [7:0]          db_s1;

	// unit state
	logic [1:0]            zero_run_q;
	logic [COUNT_BITS-1:0] occ_q;
	logic [COUNT_BITS-1:0] ub_q;
	logic                  active_q;
	logic                  lwz_q;

	// result stage
	burst_t burst_s2;

	logic                  cfg_wr;
	logic                  s2_free;
	logic                  advance;
	logic                  in_xfer;
	logic                  out_xfer;
	logic [NEED_W-1:0]     need;
	logic                  fits;
	logic                  esc;
	logic                  pad;
	logic [2:0]            add_k;
	logic [COUNT_BITS:0]   occ_sum;
	logic [COUNT_BITS:0]   ub_sum;
	logic [COUNT_BITS-1:0] occ_sat;
	logic [COUNT_BITS-1:0] ub_sat;
	logic [LEN_BITS-1:0]   len_clamp;
	logic [7:0]            hdr;
	burst_t                burst_d;
	logic [1:0]            zero_run_d;
	logic [COUNT_BITS-1:0] occ_d;
	logic [COUNT_BITS-1:0] ub_d;
	logic                  active_d;
	logic                  lwz_d;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_comb begin
		unique case (reg_idx_t'(paddr[2]))
			REG_CAPACITY: prdata = {{(32 - CAP_BITS){1'b0}}, capacity_q};
			REG_PAD:      prdata = {31'd0, pad_q};
			default:      prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= '1;
			pad_q      <= 1'b1;
		end else if (cfg_wr) begin
			unique case (reg_idx_t'(paddr[2]))
				REG_CAPACITY: capacity_q <= pwdata[CAP_BITS-1:0];
				REG_PAD:      pad_q      <= pwdata[0];
				default:      pad_q      <= pad_q;
			endcase
		end
	end

	// handshake
	assign out_valid = (burst_s2.count != 3'd0);
	assign out_xfer  = out_valid & ~out_stall;
	assign s2_free   = (burst_s2.count == 3'd0) || ((burst_s2.count == 3'd1) && !out_stall);
	assign advance   = v_s1 & s2_free;
	assign in_stall  = v_s1 & ~s2_free;
	assign in_xfer   = in_valid & ~in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= in_xfer | (v_s1 & ~advance);
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			cmd_s1  <= cmd_t'(command);
			type_s1 <= nal_type;
			ref_s1  <= ref_priority;
			len_s1  <= payload_len;
			db_s1   <= data_byte;
		end
	end

	// size check, escape decision and counter updates
	assign need = NEED_W'(occ_q) + NEED_W'(6) + NEED_W'(len_s1) + NEED_W'(len_s1 >> 1);
	assign fits = (need <= NEED_W'(capacity_q));
	assign esc  = (zero_run_q == 2'd2) && (db_s1 <= EPB);
	assign pad  = pad_q & lwz_q;
	assign hdr  = {FORBIDDEN_ZERO, ref_s1, type_s1};

	always_comb begin
		unique case (cmd_s1)
			CMD_START:   add_k = 3'd5;
			CMD_PAYLOAD: add_k = esc ? 3'd2 : 3'd1;
			CMD_END:     add_k = {2'b00, pad};
			default:     add_k = 3'd0;
		endcase
	end

	assign occ_sum = {1'b0, occ_q} + (COUNT_BITS + 1)'(add_k);
	assign ub_sum  = {1'b0, ub_q} + (COUNT_BITS + 1)'(add_k);
	assign occ_sat = occ_sum[COUNT_BITS] ? '1 : occ_sum[COUNT_BITS-1:0];
	assign ub_sat  = ub_sum[COUNT_BITS] ? '1 : ub_sum[COUNT_BITS-1:0];

	generate
		if (COUNT_BITS > LEN_BITS) begin : g_len_clamp
			assign len_clamp = (|ub_sat[COUNT_BITS-1:LEN_BITS]) ? '1 : ub_sat[LEN_BITS-1:0];
		end else begin : g_len_ext
			assign len_clamp = LEN_BITS'(ub_sat);
		end
	endgenerate

	always_comb begin
		burst_d           = '0;
		burst_d.tail_kind = KIND_BYTE;
		zero_run_d        = zero_run_q;
		occ_d             = occ_q;
		ub_d              = ub_q;
		active_d          = active_q;
		lwz_d             = lwz_q;
		unique case (cmd_s1)
			CMD_START: begin
				active_d = fits;
				if (fits) begin
					burst_d.count    = 3'd5;
					burst_d.bytes[0] = START_PREFIX[0];
					burst_d.bytes[1] = START_PREFIX[1];
					burst_d.bytes[2] = START_PREFIX[2];
					burst_d.bytes[3] = START_PREFIX[3];
					burst_d.bytes[4] = hdr;
					occ_d            = occ_sat;
					ub_d             = COUNT_BITS'(5);
					zero_run_d       = 2'd0;
					lwz_d            = (hdr == 8'h00);
				end else begin
					burst_d.count     = 3'd1;
					burst_d.tail_kind = KIND_FULL;
				end
			end
			CMD_PAYLOAD: begin
				if (active_q) begin
					if (esc) begin
						burst_d.count    = 3'd2;
						burst_d.bytes[0] = EPB;
						burst_d.bytes[1] = db_s1;
					end else begin
						burst_d.count    = 3'd1;
						burst_d.bytes[0] = db_s1;
					end
					occ_d = occ_sat;
					ub_d  = ub_sat;
					lwz_d = (db_s1 == 8'h00);
					if (db_s1 == 8'h00) begin
						if (esc) begin
							zero_run_d = 2'd1;
						end else begin
							zero_run_d = (zero_run_q == 2'd2) ? 2'd2 : zero_run_q + 2'd1;
						end
					end else begin
						zero_run_d = 2'd0;
					end
				end
			end
			CMD_END: begin
				if (active_q) begin
					if (pad) begin
						burst_d.count    = 3'd2;
						burst_d.bytes[0] = EPB;
					end else begin
						burst_d.count    = 3'd1;
					end
					burst_d.tail_kind = KIND_DONE;
					burst_d.tail_len  = len_clamp;
					occ_d             = occ_sat;
					ub_d              = ub_sat;
					active_d          = 1'b0;
					zero_run_d        = 2'd0;
					lwz_d             = 1'b0;
				end
			end
			CMD_CLEAR: begin
				zero_run_d = 2'd0;
				occ_d      = '0;
				ub_d       = '0;
				active_d   = 1'b0;
				lwz_d      = 1'b0;
			end
			default: begin
				active_d = active_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_run_q <= 2'd0;
			occ_q      <= '0;
			ub_q       <= '0;
			active_q   <= 1'b0;
			lwz_q      <= 1'b0;
		end else if (advance) begin
			zero_run_q <= zero_run_d;
			occ_q      <= occ_d;
			ub_q       <= ub_d;
			active_q   <= active_d;
			lwz_q      <= lwz_d;
		end
	end

	// result stage: load a new burst or advance through the current one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			burst_s2 <= '0;
		end else if (advance) begin
			burst_s2 <= burst_d;
		end else if (out_xfer) begin
			burst_s2.count <= burst_s2.count - 3'd1;
			burst_s2.bytes <= burst_s2.bytes >> 8;
		end
	end

	assign last        = (burst_s2.count == 3'd1);
	assign out_byte    = burst_s2.bytes[0];
	assign kind        = last ? burst_s2.tail_kind : KIND_BYTE;
	assign unit_length = last ? burst_s2.tail_len : '0;

endmodule

`default_nettype wire
